// File: rtl/core/srp_pkg.sv
// Package for the shelf rectangle packer: transaction types and default sizes.
package srp_pkg;

  localparam int unsigned MaxRectsDefault = 32;
  localparam int unsigned DimBitsDefault  = 12;
  localparam int unsigned InDimWidth      = 12;
  localparam int unsigned PosXWidth       = 14;
  localparam int unsigned PosYWidth       = 17;

  typedef struct packed {
    logic [InDimWidth-1:0] rect_width;
    logic [InDimWidth-1:0] rect_height;
    logic                  final_item;
  } srp_in_t;

  typedef struct packed {
    logic [PosXWidth-1:0] pos_x;
    logic [PosYWidth-1:0] pos_y;
    logic [PosXWidth-1:0] out_width;
    logic [PosYWidth-1:0] out_height;
    logic                 is_total;
    logic                 run_end;
  } srp_out_t;

endpackage

// File: rtl/core/srp_cell.sv
// One cell of the insertion sorting chain: holds one rectangle, ordered by height.
module srp_cell #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                ins_i,
  input  logic                shift_i,
  input  logic [DIM_BITS-1:0] new_w_i,
  input  logic [DIM_BITS-1:0] new_h_i,
  input  logic                left_keep_i,
  input  logic [DIM_BITS-1:0] left_w_i,
  input  logic [DIM_BITS-1:0] left_h_i,
  input  logic                left_valid_i,
  input  logic [DIM_BITS-1:0] right_w_i,
  input  logic [DIM_BITS-1:0] right_h_i,
  input  logic                right_valid_i,
  output logic [DIM_BITS-1:0] w_o,
  output logic [DIM_BITS-1:0] h_o,
  output logic                valid_o,
  output logic                keep_o
);

  logic [DIM_BITS-1:0] w_q, h_q;
  logic                valid_q;

  // A cell keeps its entry when it is at least as tall as the incoming one,
  // so equal heights stay in arrival order.
  assign keep_o  = valid_q && (h_q >= new_h_i);
  assign w_o     = w_q;
  assign h_o     = h_q;
  assign valid_o = valid_q;

  // Valid bit: moves with the entry on insertion and on unloading.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ins_i && !keep_o) begin
      valid_q <= left_keep_i ? 1'b1 : left_valid_i;
    end else if (shift_i) begin
      valid_q <= right_valid_i;
    end
  end

  // Payload: the new rectangle lands just after the last kept cell, the
  // entries behind it move one place down; unloading moves all up one place.
  always_ff @(posedge clk_i) begin
    if (ins_i && !keep_o) begin
      if (left_keep_i) begin
        w_q <= new_w_i;
        h_q <= new_h_i;
      end else begin
        w_q <= left_w_i;
        h_q <= left_h_i;
      end
    end else if (shift_i) begin
      w_q <= right_w_i;
      h_q <= right_h_i;
    end
  end

endmodule

// File: rtl/core/srp_packer.sv
// Shelf placement unit: places one sorted rectangle per cycle and emits results.
module srp_packer #(
  parameter int unsigned DIM_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                place_i,
  input  logic                total_i,
  input  logic [DIM_BITS-1:0] w_i,
  input  logic [DIM_BITS-1:0] h_i,
  input  logic [DIM_BITS-1:0] widest_i,
  output srp_pkg::srp_out_t   result_o,
  output logic                result_valid_o
);
  import srp_pkg::*;

  localparam int unsigned LimW = DIM_BITS + 2;
  localparam int unsigned SumW = DIM_BITS + 3;
  localparam int unsigned YW   = DIM_BITS + 6;

  logic [LimW-1:0] cx_q, cx_d, limit, px;
  logic [YW-1:0]   cy_q, cy_d, py, tot_h;
  logic [DIM_BITS-1:0] shelf_q, shelf_d;
  logic            first_q;
  logic [SumW-1:0] right_edge;
  logic            overflow;
  logic [31:0]     px_ext, py_ext, w_ext, h_ext, lim_ext, toth_ext;
  srp_out_t        res_d, res_q;
  logic            res_valid_q;

  // Shelf limit and the test whether the rectangle still fits on this shelf.
  assign limit      = {widest_i, 2'b00};
  assign right_edge = SumW'(cx_q) + SumW'(w_i);
  assign overflow   = !first_q && (right_edge > SumW'(limit));
  assign tot_h      = cy_q + YW'(shelf_q);

  // Placement of the current rectangle and the cursor update.
  always_comb begin
    if (overflow) begin
      px      = '0;
      py      = tot_h;
      shelf_d = h_i;
      cx_d    = LimW'(w_i);
    end else begin
      px      = cx_q;
      py      = cy_q;
      shelf_d = first_q ? h_i : shelf_q;
      cx_d    = LimW'(right_edge);
    end
    cy_d = py;
  end

  // Result formatting: every field is cut to its transaction width.
  assign px_ext   = 32'(px);
  assign py_ext   = 32'(py);
  assign w_ext    = 32'(w_i);
  assign h_ext    = 32'(h_i);
  assign lim_ext  = 32'(limit);
  assign toth_ext = 32'(tot_h);

  always_comb begin
    if (total_i) begin
      res_d.pos_x      = '0;
      res_d.pos_y      = '0;
      res_d.out_width  = lim_ext[PosXWidth-1:0];
      res_d.out_height = toth_ext[PosYWidth-1:0];
      res_d.is_total   = 1'b1;
      res_d.run_end    = 1'b1;
    end else begin
      res_d.pos_x      = px_ext[PosXWidth-1:0];
      res_d.pos_y      = py_ext[PosYWidth-1:0];
      res_d.out_width  = w_ext[PosXWidth-1:0];
      res_d.out_height = h_ext[PosYWidth-1:0];
      res_d.is_total   = 1'b0;
      res_d.run_end    = 1'b0;
    end
  end

  // Cursor state, cleared after the total transaction of each run.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '0;
      cy_q        <= '0;
      shelf_q     <= '0;
      first_q     <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= place_i || total_i;
      if (total_i) begin
        cx_q    <= '0;
        cy_q    <= '0;
        shelf_q <= '0;
        first_q <= 1'b1;
      end else if (place_i) begin
        cx_q    <= cx_d;
        cy_q    <= cy_d;
        shelf_q <= shelf_d;
        first_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (place_i || total_i) begin
      res_q <= res_d;
    end
  end

  assign result_o       = res_q;
  assign result_valid_o = res_valid_q;

endmodule

// File: rtl/core/shelf_rectangle_packer.sv
// Top level of the shelf rectangle packer: sorting chain, control and placement.
//
// Usage: rectangles are loaded one per transaction on item_i, taken at a
// rising edge where start_i is high and busy_o is low. Loading costs one
// cycle per rectangle: each enters a chain of MAX_RECTS cells that keeps
// the set ordered by descending height, equal heights in arrival order.
// Rectangles beyond MAX_RECTS are dropped. The transaction with final_item
// set starts packing; busy_o is then high until the run is finished.
// Packing unloads the chain one cell per cycle into the shelf placement
// unit, so a run of N rectangles gives N placement results followed by one
// total result (is_total and run_end set), one per cycle. Once the state
// register holds packing, results leave via the placer's result register;
// busy_o falls as the total result is formed. Each result is on result_o
// for one cycle, marked by result_valid_o; the receiver cannot stall, so
// no result waits. Reset empties the chain and clears all cursors; the
// block accepts a transaction in the first cycle after reset.
module shelf_rectangle_packer #(
  parameter int unsigned MAX_RECTS = srp_pkg::MaxRectsDefault,
  parameter int unsigned DIM_BITS  = srp_pkg::DimBitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  srp_pkg::srp_in_t  item_i,
  output logic              busy_o,
  output srp_pkg::srp_out_t result_o,
  output logic              result_valid_o
);
  import srp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_RECTS + 1);

  typedef enum logic {
    ST_LOAD,
    ST_PACK
  } state_e;

  state_e              state_q;
  logic [CntW-1:0]     count_q;
  logic [DIM_BITS-1:0] widest_q;
  logic                accept, ins, shift, place, total;
  logic [31:0]         in_w_ext, in_h_ext;
  logic [DIM_BITS-1:0] new_w, new_h;

  logic [DIM_BITS-1:0] cw [MAX_RECTS];
  logic [DIM_BITS-1:0] ch [MAX_RECTS];
  logic                cv [MAX_RECTS];
  logic                ck [MAX_RECTS];

  // Input handshake and dimension extraction.
  assign accept   = start_i && (state_q == ST_LOAD);
  assign ins      = accept && (count_q < CntW'(MAX_RECTS));
  assign in_w_ext = 32'(item_i.rect_width);
  assign in_h_ext = 32'(item_i.rect_height);
  assign new_w    = in_w_ext[DIM_BITS-1:0];
  assign new_h    = in_h_ext[DIM_BITS-1:0];

  // Packing control: the head cell feeds the placer while it holds an entry.
  assign place = (state_q == ST_PACK) && cv[0];
  assign total = (state_q == ST_PACK) && !cv[0];
  assign shift = place;
  assign busy_o = (state_q == ST_PACK);

  // The sorting chain.
  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    logic                lkeep, lvalid, rvalid;
    logic [DIM_BITS-1:0] lw, lh, rw, rh;

    if (i == 0) begin : g_head
      assign lkeep  = 1'b1;
      assign lw     = '0;
      assign lh     = '0;
      assign lvalid = 1'b0;
    end else begin : g_body
      assign lkeep  = ck[i-1];
      assign lw     = cw[i-1];
      assign lh     = ch[i-1];
      assign lvalid = cv[i-1];
    end

    if (i == MAX_RECTS - 1) begin : g_tail
      assign rw     = '0;
      assign rh     = '0;
      assign rvalid = 1'b0;
    end else begin : g_mid
      assign rw     = cw[i+1];
      assign rh     = ch[i+1];
      assign rvalid = cv[i+1];
    end

    srp_cell #(
      .DIM_BITS(DIM_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ins_i        (ins),
      .shift_i      (shift),
      .new_w_i      (new_w),
      .new_h_i      (new_h),
      .left_keep_i  (lkeep),
      .left_w_i     (lw),
      .left_h_i     (lh),
      .left_valid_i (lvalid),
      .right_w_i    (rw),
      .right_h_i    (rh),
      .right_valid_i(rvalid),
      .w_o          (cw[i]),
      .h_o          (ch[i]),
      .valid_o      (cv[i]),
      .keep_o       (ck[i])
    );
  end

  // Run control: fill count, widest width and load/pack state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      widest_q <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (ins) begin
            count_q <= count_q + CntW'(1);
            if (new_w > widest_q) begin
              widest_q <= new_w;
            end
          end
          if (accept && item_i.final_item) begin
            state_q <= ST_PACK;
          end
        end
        ST_PACK: begin
          if (total) begin
            state_q  <= ST_LOAD;
            count_q  <= '0;
            widest_q <= '0;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  // Shelf placement and result register.
  srp_packer #(
    .DIM_BITS(DIM_BITS)
  ) u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .place_i       (place),
    .total_i       (total),
    .w_i           (cw[0]),
    .h_i           (ch[0]),
    .widest_i      (widest_q),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the shelf rectangle packer: layout prediction and result checks.
module testbench;
  import srp_pkg::*;

  localparam int unsigned ShelfFactor = 4;
  localparam int unsigned ItemTarget  = 270;
  localparam int unsigned PackSettle  = 4;
  localparam int unsigned EndSettle   = 40;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned GapPercent  = 32;

  // Predicts the placements of each rectangle set and checks the block's results against them.
  class shelf_layout_model;
    logic [InDimWidth-1:0] held_w[MaxRectsDefault];
    logic [InDimWidth-1:0] held_h[MaxRectsDefault];
    int unsigned           held_count;
    int unsigned           widest;
    srp_out_t              pending_layout[$];
    int unsigned           mismatches;
    int unsigned           placements_seen;
    int unsigned           totals_seen;
    int unsigned           sets_packed;
    int unsigned           rects_dropped;

    function new();
      held_count      = 0;
      widest          = 0;
      mismatches      = 0;
      placements_seen = 0;
      totals_seen     = 0;
      sets_packed     = 0;
      rects_dropped   = 0;
    endfunction

    function srp_out_t layout_entry(int unsigned x, int unsigned y, int unsigned w,
                                    int unsigned h, logic total);
      srp_out_t r;
      r.pos_x      = PosXWidth'(x);
      r.pos_y      = PosYWidth'(y);
      r.out_width  = PosXWidth'(w);
      r.out_height = PosYWidth'(h);
      r.is_total   = total;
      r.run_end    = total;
      return r;
    endfunction

    // Notes an accepted rectangle; the final one of a set yields the whole layout.
    function void note_rect(srp_in_t it);
      int unsigned pos;
      int unsigned limit;
      int unsigned cur_x;
      int unsigned cur_y;
      int unsigned shelf_h;
      // Insertion keeps descending height; equal heights stay in arrival order.
      if (held_count < MaxRectsDefault) begin
        pos = held_count;
        while (pos > 0 && held_h[pos-1] < it.rect_height) begin
          held_w[pos] = held_w[pos-1];
          held_h[pos] = held_h[pos-1];
          pos--;
        end
        held_w[pos] = it.rect_width;
        held_h[pos] = it.rect_height;
        held_count++;
        if (it.rect_width > widest) widest = it.rect_width;
      end else begin
        rects_dropped++;
      end
      if (!it.final_item) return;

      // Next-fit placement onto shelves of width four times the widest rectangle.
      limit   = widest * ShelfFactor;
      cur_x   = 0;
      cur_y   = 0;
      shelf_h = held_h[0];
      for (int unsigned i = 0; i < held_count; i++) begin
        if (cur_x + held_w[i] > limit) begin
          cur_x   = 0;
          cur_y  += shelf_h;
          shelf_h = held_h[i];
        end
        pending_layout.push_back(layout_entry(cur_x, cur_y, held_w[i], held_h[i], 1'b0));
        cur_x += held_w[i];
      end
      pending_layout.push_back(layout_entry(0, 0, limit, cur_y + shelf_h, 1'b1));
      sets_packed++;
      held_count = 0;
      widest     = 0;
    endfunction

    function void report(string what, srp_out_t want, srp_out_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch (%s): expected x=%0d y=%0d w=%0d h=%0d tot=%0b end=%0b",
                 what, want.pos_x, want.pos_y, want.out_width, want.out_height,
                 want.is_total, want.run_end);
        $display("  got x=%0d y=%0d w=%0d h=%0d tot=%0b end=%0b",
                 got.pos_x, got.pos_y, got.out_width, got.out_height,
                 got.is_total, got.run_end);
      end
    endfunction

    // Compares one result transaction with the oldest expected layout entry.
    function void check_placement(srp_out_t got);
      srp_out_t want;
      if (pending_layout.size() == 0) begin
        report("no result expected", '0, got);
        return;
      end
      want = pending_layout.pop_front();
      if (want.is_total) totals_seen++;
      else placements_seen++;
      if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
          got.out_width !== want.out_width || got.out_height !== want.out_height ||
          got.is_total !== want.is_total || got.run_end !== want.run_end)
        report("wrong field", want, got);
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  srp_in_t  item_i;
  logic     busy_o;
  srp_out_t result_o;
  logic     result_valid_o;

  shelf_layout_model book;
  int unsigned       rects_accepted;
  int unsigned       rects_sent;
  int unsigned       cycle_count;
  bit                quiet;

  shelf_rectangle_packer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .item_i        (item_i),
    .busy_o        (busy_o),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watches both sides at the rising edge: results are checked before the input is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) book.check_placement(result_o);
      if (start_i && !busy_o) begin
        book.note_rect(item_i);
        rects_accepted++;
      end
    end
  end

  // Guards against a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Lowers start for a number of cycles, with noise on the idle item bus.
  task automatic hold_off(input int unsigned cycles);
    logic [31:0] noise;
    noise = $urandom;
    start_i <= 1'b0;
    item_i  <= noise[$bits(srp_in_t)-1:0];
    repeat (cycles) @(negedge clk_i);
  endtask

  // Presents one rectangle, idling first on random cycles, and waits for its transaction.
  task automatic send_rect(input int unsigned w, input int unsigned h, input bit last);
    srp_in_t     it;
    int unsigned goal;
    while (!quiet && $urandom_range(99) < GapPercent) hold_off(1);
    it.rect_width  = InDimWidth'(w);
    it.rect_height = InDimWidth'(h);
    it.final_item  = last;
    goal           = rects_accepted + 1;
    start_i <= 1'b1;
    item_i  <= it;
    rects_sent++;
    do @(negedge clk_i); while (rects_accepted < goal);
  endtask

  // Holds the sender back until every expected result has arrived.
  task automatic await_layouts();
    start_i <= 1'b0;
    while (book.pending_layout.size() != 0) @(negedge clk_i);
    repeat (PackSettle) @(negedge clk_i);
  endtask

  // Sends one random set; the shapes of widths and heights are chosen per set.
  task automatic send_random_set(input int unsigned count);
    int unsigned w_style;
    int unsigned h_style;
    int unsigned w;
    int unsigned h;
    w_style = $urandom_range(3);
    h_style = $urandom_range(2);
    for (int unsigned i = 0; i < count; i++) begin
      case (w_style)
        0: w = $urandom_range(4095);
        1: w = $urandom_range(15);
        2: w = $urandom_range(3000, 4095);
        default: w = ($urandom_range(9) == 0) ? $urandom_range(4095) : 0;
      endcase
      case (h_style)
        0: h = $urandom_range(4095);
        1: h = $urandom_range(7);
        default: h = ($urandom_range(3) == 0) ? 4095 : $urandom_range(4095);
      endcase
      send_rect(w, h, i == count - 1);
    end
  endtask

  initial begin
    int unsigned set_index;
    int unsigned pick;
    int unsigned count;
    book           = new();
    rects_accepted = 0;
    rects_sent     = 0;
    quiet          = 1'b0;
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    item_i         = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A single rectangle of the largest size.
    send_rect(4095, 4095, 1'b1);
    // Zero widths give a zero limit, so all share one shelf.
    send_rect(0, 0, 1'b0);
    send_rect(0, 4095, 1'b0);
    send_rect(0, 0, 1'b1);
    // Equal heights must keep their arrival order.
    send_rect(100, 7, 1'b0);
    send_rect(300, 7, 1'b0);
    send_rect(200, 9, 1'b0);
    send_rect(50, 7, 1'b0);
    send_rect(1, 0, 1'b1);
    // Four widest rectangles fill the shelf exactly; the fifth opens a new one.
    for (int unsigned i = 1; i <= 5; i++) send_rect(4095, i, i == 5);
    // Alternating bit patterns.
    send_rect(12'h555, 12'hAAA, 1'b0);
    send_rect(12'hAAA, 12'h555, 1'b1);
    await_layouts();

    // Random sets: mostly short, some long, and a few that overfill the store.
    set_index = 0;
    while (rects_sent < ItemTarget) begin
      quiet = (set_index >= 6 && set_index <= 10);
      pick  = $urandom_range(99);
      if (set_index == 3 || set_index == 12 || pick < 4) count = $urandom_range(33, 36);
      else if (pick < 70) count = $urandom_range(1, 8);
      else if (pick < 90) count = $urandom_range(9, 24);
      else count = $urandom_range(25, 32);
      send_random_set(count);
      if (set_index == 8) await_layouts();
      set_index++;
    end
    quiet = 1'b0;

    await_layouts();
    repeat (EndSettle) @(negedge clk_i);
    $display("Covered %0d sets from %0d loaded rectangles, %0d dropped on a full store.",
             book.sets_packed, rects_accepted, book.rects_dropped);
    $display("Checked %0d placements and %0d totals; %0d mismatches.",
             book.placements_seen, book.totals_seen, book.mismatches);
    if (book.mismatches == 0 && book.pending_layout.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/srp_pkg.sv
rtl/core/srp_cell.sv
rtl/core/srp_packer.sv
rtl/core/shelf_rectangle_packer.sv
sim/testbench.sv
